### rtl/core/sitda_pkg.sv
// shared constants, types and helpers for the signed integer to decimal ascii unit
// no dependencies; used by sitda_dabble and signed_integer_to_decimal_ascii_unit
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned NUM_DIG = 10;
	localparam int unsigned BCD_W   = 4 * NUM_DIG;
	localparam int unsigned CNT_W   = $clog2(VALUE_W);
	localparam int unsigned IDX_W   = $clog2(NUM_DIG);
	localparam int unsigned CHAR_W  = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	// conversion result handed from the dabble unit to the sequencer
	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} dab_res_t;

	// double-dabble digit correction: add 3 to any digit of 5 or more
	function automatic logic [3:0] add3(input logic [3:0] d);
		logic [3:0] r;
		r = (d >= 4'd5) ? d + 4'd3 : d;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/sitda_dabble.sv
// iterative binary to bcd converter, one shift-add-3 step per cycle
// depends on sitda_pkg
`timescale 1ns / 1ps
`default_nettype none

module sitda_dabble (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [sitda_pkg::VALUE_W-1:0]  mag,
	output sitda_pkg::dab_res_t                 res
);

	logic [sitda_pkg::VALUE_W-1:0] mag_q;
	logic [sitda_pkg::BCD_W-1:0]   bcd_q;
	logic [sitda_pkg::CNT_W-1:0]   cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [sitda_pkg::BCD_W-1:0]   adj;

	// correct every digit, all independent
	always_comb begin
		for (int i = 0; i < sitda_pkg::NUM_DIG; i++) begin
			adj[4*i +: 4] = sitda_pkg::add3(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sitda_pkg::CNT_W'(sitda_pkg::VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[sitda_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[sitda_pkg::BCD_W-2:0], mag_q[sitda_pkg::VALUE_W-1]};
		end
	end

	assign res.done = done_q;
	assign res.bcd  = bcd_q;

endmodule

`default_nettype wire

### rtl/core/signed_integer_to_decimal_ascii_unit.sv
// top level: signed 32-bit integer to decimal ascii character stream
// depends on sitda_pkg and sitda_dabble
`timescale 1ns / 1ps
`default_nettype none

// usage
//   slave side (s_*): one word per integer, s_tdata holds the two's complement
//   value. a word is taken when s_tvalid and s_tready are both high.
//   master side (m_*): one word per ascii character, '-' first for a negative
//   value, then the digits most significant first with no leading zeros;
//   m_tlast marks the last character of each value.
// timing
//   after a word is taken the shared shift-add-3 unit shifts in one bit per
//   cycle; the result is latched in the cycle after the last step and characters
//   leave the output register one per cycle while m_tready is high.
//   s_tready is high only while the sequencer is idle, so one value is in
//   flight at a time; the last character may still sit in the output register
//   while the next value is taken.
// stalls and reset
//   a low m_tready holds the output register and the sequencer; nothing is
//   dropped. arst_n clears the sequencer and the output valid; no clearing
//   pass is needed and the block keeps nothing between values.
module signed_integer_to_decimal_ascii_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,   // [7:0] character
	output      logic        m_tlast    // last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CONV  = 2'd1;
	localparam logic [1:0] ST_SIGN  = 2'd2;
	localparam logic [1:0] ST_DIGIT = 2'd3;

	logic [1:0]                      state_q;
	logic                            neg_q;
	logic [sitda_pkg::BCD_W-1:0]     bcd_q;
	logic [sitda_pkg::IDX_W-1:0]     idx_q;
	logic                            m_tvalid_q;
	logic [sitda_pkg::CHAR_W-1:0]    m_tdata_q;
	logic                            m_tlast_q;

	logic                            in_acc;
	logic                            out_free;
	logic [sitda_pkg::VALUE_W-1:0]   mag;
	sitda_pkg::dab_res_t             res;
	logic [sitda_pkg::IDX_W-1:0]     msd;
	logic [3:0]                      digit_sel;
	logic                            load;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// magnitude in unsigned arithmetic, so the most negative value stays exact
	assign mag = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;

	sitda_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.mag    (mag),
		.res    (res)
	);

	// index of the most significant nonzero digit, zero for a zero value
	always_comb begin
		msd = '0;
		for (int i = 0; i < sitda_pkg::NUM_DIG; i++) begin
			if (res.bcd[4*i +: 4] != 4'd0) begin
				msd = sitda_pkg::IDX_W'(i);
			end
		end
	end

	assign digit_sel = bcd_q[4*idx_q +: 4];

	// a character goes into the output register in sign or digit state
	assign load = ((state_q == ST_SIGN) || (state_q == ST_DIGIT)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (res.done) begin
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_free && idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q <= s_tdata[31];
		end
		if (state_q == ST_CONV && res.done) begin
			bcd_q <= res.bcd;
			idx_q <= msd;
		end else if (state_q == ST_DIGIT && out_free && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
		if (load) begin
			if (state_q == ST_SIGN) begin
				m_tdata_q <= sitda_pkg::ASCII_MINUS;
				m_tlast_q <= 1'b0;
			end else begin
				m_tdata_q <= sitda_pkg::ASCII_ZERO + {4'd0, digit_sel};
				m_tlast_q <= (idx_q == '0);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// converter only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> state_q == ST_CONV)
		else $error("conversion done outside conv state");

	// the digit being emitted is a valid decimal digit
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIGIT |-> digit_sel <= 4'd9)
		else $error("digit out of range");

	// loading the final character returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_DIGIT && idx_q == '0) |=> state_q == ST_IDLE)
		else $error("sequencer not idle after last character");

	// an accepted value moves the sequencer to conv state with the conversion not yet done
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_CONV && !res.done)
		else $error("accept did not start a conversion");

endmodule

`default_nettype wire
